[design/tgpg_pkg.sv]
`default_nettype none
package tgpg_pkg;

  localparam int TEXT_DEPTH_DEF = 256;
  localparam int FONT_BYTES_DEF = 4096;

  localparam int DIV_STEPS  = 10;
  localparam int GLYPH_BASE = 4;
  localparam int FIRST_CODE = 32;
  localparam int IDX_W      = 19;
  localparam int GADDR_W    = 18;

  typedef enum logic [1:0] {
    OP_QUERY = 2'd0,
    OP_TEXT  = 2'd1,
    OP_GLYPH = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_GLYPH_WIDTH  = 2'd0,
    REG_GLYPH_HEIGHT = 2'd1,
    REG_WINDOW_WIDTH = 2'd2,
    REG_TEXT_LENGTH  = 2'd3
  } reg_idx_t;

  typedef struct packed {
    logic        valid;
    op_t         op;
    logic [11:0] wa;
    logic [7:0]  wd;
    logic [2:0]  px_lo;
    logic [9:0]  na;
    logic [9:0]  nb;
    logic [9:0]  nc;
    logic [9:0]  qa;
    logic [9:0]  qb;
    logic [9:0]  qc;
    logic [5:0]  ra;
    logic [2:0]  rb;
    logic [2:0]  rc;
  } div_stage_t;

endpackage
`default_nettype wire

[design/text_glyph_pixel_generator_top.sv]
`default_nettype none
// Channel   Dir  Handshake              Payload
// s_*       in   s_tvalid / s_tready    query or store write request
// m_*       out  m_tvalid / m_tready    pixel_on result, queries only
// apb       in   psel/penable/pwrite    glyph and window registers
// One request a cycle unless the result is stalled; a query after acceptance passes
// an input register and ten bit-serial division stages for row, column and line length,
// then cell multiply, text memory read, glyph address multiply, glyph read.
// Writes land at the text or glyph memory port stage, so order is kept.
// A stalled result freezes the whole pipeline. rst clears valid bits and
// registers; both memories are undefined until written.
module text_glyph_pixel_generator_top #(
  parameter int TEXT_DEPTH = tgpg_pkg::TEXT_DEPTH_DEF,
  parameter int FONT_BYTES = tgpg_pkg::FONT_BYTES_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  // pixel_x[9:0], pixel_y[19:10], write_address[31:20], write_data[39:32]
  input  wire logic [39:0] s_tdata,
  // opcode[1:0]
  input  wire logic [1:0]  s_tuser,
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // pixel_on[0], zero fill above
  output logic [7:0]       m_tdata,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);

  localparam int TA_W = $clog2(TEXT_DEPTH);
  localparam int GA_W = $clog2(FONT_BYTES);
  localparam int NS   = tgpg_pkg::DIV_STEPS;

  logic [5:0]  glyph_width;
  logic [5:0]  glyph_height;
  logic [10:0] window_width;
  logic [8:0]  text_length;
  logic [8:0]  bpg;

  logic [7:0] text_mem  [TEXT_DEPTH];
  logic [7:0] glyph_mem [FONT_BYTES];

  tgpg_pkg::div_stage_t d [NS+1];

  logic                        e_valid, e_ok;
  tgpg_pkg::op_t               e_op;
  logic [11:0]                 e_wa;
  logic [7:0]                  e_wd;
  logic [2:0]                  e_px_lo;
  logic [tgpg_pkg::IDX_W-1:0]  e_idx;
  logic [9:0]                  e_base;

  logic                        f_valid, f_ok;
  tgpg_pkg::op_t               f_op;
  logic [11:0]                 f_wa;
  logic [7:0]                  f_wd;
  logic [2:0]                  f_px_lo;
  logic [9:0]                  f_base;
  logic [7:0]                  f_code;

  logic                        g_valid, g_ok;
  tgpg_pkg::op_t               g_op;
  logic [11:0]                 g_wa;
  logic [7:0]                  g_wd;
  logic [2:0]                  g_px_lo;
  logic [tgpg_pkg::GADDR_W-1:0] g_addr;

  logic                        h_valid, h_ok;
  tgpg_pkg::op_t               h_op;
  logic [2:0]                  h_px_lo;
  logic [7:0]                  h_glyph;

  logic       adv;
  logic [2:0] k;
  logic       cfg_wr;

  assign k      = glyph_width[5:3];
  assign adv    = !m_tvalid || m_tready;
  assign s_tready = adv;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      glyph_width  <= 6'd8;
      glyph_height <= 6'd8;
      window_width <= 11'd240;
      text_length  <= 9'd0;
    end else if (cfg_wr) begin
      case (tgpg_pkg::reg_idx_t'(paddr[3:2]))
        tgpg_pkg::REG_GLYPH_WIDTH:  glyph_width  <= pwdata[5:0];
        tgpg_pkg::REG_GLYPH_HEIGHT: glyph_height <= pwdata[5:0];
        tgpg_pkg::REG_WINDOW_WIDTH: window_width <= pwdata[10:0];
        tgpg_pkg::REG_TEXT_LENGTH:  text_length  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (tgpg_pkg::reg_idx_t'(paddr[3:2]))
      tgpg_pkg::REG_GLYPH_WIDTH:  prdata = {26'd0, glyph_width};
      tgpg_pkg::REG_GLYPH_HEIGHT: prdata = {26'd0, glyph_height};
      tgpg_pkg::REG_WINDOW_WIDTH: prdata = {21'd0, window_width};
      tgpg_pkg::REG_TEXT_LENGTH:  prdata = {23'd0, text_length};
      default:                    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    bpg <= 9'(k * glyph_height);
  end

  // restoring division, one quotient bit per stage
  always_ff @(posedge clk) begin
    logic [6:0] sa;
    logic [3:0] sb, sc;
    if (rst) begin
      for (int i = 0; i <= NS; i++) d[i].valid <= 1'b0;
    end else if (adv) begin
      d[0].valid <= s_tvalid;
      d[0].op    <= tgpg_pkg::op_t'(s_tuser);
      d[0].wa    <= s_tdata[31:20];
      d[0].wd    <= s_tdata[39:32];
      d[0].px_lo <= s_tdata[2:0];
      d[0].na    <= s_tdata[19:10];
      d[0].nb    <= {3'd0, s_tdata[9:3]};
      d[0].nc    <= {2'd0, window_width[10:3]};
      d[0].qa    <= 10'd0;
      d[0].qb    <= 10'd0;
      d[0].qc    <= 10'd0;
      d[0].ra    <= 6'd0;
      d[0].rb    <= 3'd0;
      d[0].rc    <= 3'd0;
      for (int i = 1; i <= NS; i++) begin
        sa = {d[i-1].ra, d[i-1].na[9]};
        sb = {d[i-1].rb, d[i-1].nb[9]};
        sc = {d[i-1].rc, d[i-1].nc[9]};
        d[i].valid <= d[i-1].valid;
        d[i].op    <= d[i-1].op;
        d[i].wa    <= d[i-1].wa;
        d[i].wd    <= d[i-1].wd;
        d[i].px_lo <= d[i-1].px_lo;
        d[i].na    <= {d[i-1].na[8:0], 1'b0};
        d[i].nb    <= {d[i-1].nb[8:0], 1'b0};
        d[i].nc    <= {d[i-1].nc[8:0], 1'b0};
        if (sa >= {1'b0, glyph_height}) begin
          d[i].ra <= 6'(sa - {1'b0, glyph_height});
          d[i].qa <= {d[i-1].qa[8:0], 1'b1};
        end else begin
          d[i].ra <= sa[5:0];
          d[i].qa <= {d[i-1].qa[8:0], 1'b0};
        end
        if (sb >= {1'b0, k}) begin
          d[i].rb <= 3'(sb - {1'b0, k});
          d[i].qb <= {d[i-1].qb[8:0], 1'b1};
        end else begin
          d[i].rb <= sb[2:0];
          d[i].qb <= {d[i-1].qb[8:0], 1'b0};
        end
        if (sc >= {1'b0, k}) begin
          d[i].rc <= 3'(sc - {1'b0, k});
          d[i].qc <= {d[i-1].qc[8:0], 1'b1};
        end else begin
          d[i].rc <= sc[2:0];
          d[i].qc <= {d[i-1].qc[8:0], 1'b0};
        end
      end
    end
  end

  // cell index and in-glyph byte offset
  always_ff @(posedge clk) begin
    if (rst) begin
      e_valid <= 1'b0;
    end else if (adv) begin
      e_valid <= d[NS].valid;
      e_op    <= d[NS].op;
      e_wa    <= d[NS].wa;
      e_wd    <= d[NS].wd;
      e_px_lo <= d[NS].px_lo;
      e_ok    <= (k != 3'd0) && (glyph_height != 6'd0) && (d[NS].qc[7:0] != 8'd0)
                 && (d[NS].qb[6:0] < d[NS].qc[7:0]);
      e_idx   <= tgpg_pkg::IDX_W'(d[NS].qa * d[NS].qc[7:0])
                 + tgpg_pkg::IDX_W'(d[NS].qb[6:0]);
      e_base  <= 10'(tgpg_pkg::GLYPH_BASE) + 10'(d[NS].ra * k) + 10'(d[NS].rb);
    end
  end

  // text memory port
  always_ff @(posedge clk) begin
    if (adv) begin
      if (e_valid && e_op == tgpg_pkg::OP_TEXT && {1'b0, e_wa} < 13'(TEXT_DEPTH)) begin
        text_mem[TA_W'(e_wa)] <= e_wd;
      end
      f_code <= text_mem[e_idx[TA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f_valid <= 1'b0;
    end else if (adv) begin
      f_valid <= e_valid;
      f_op    <= e_op;
      f_wa    <= e_wa;
      f_wd    <= e_wd;
      f_px_lo <= e_px_lo;
      f_base  <= e_base;
      f_ok    <= e_ok && (e_idx < tgpg_pkg::IDX_W'(text_length))
                 && (e_idx < tgpg_pkg::IDX_W'(TEXT_DEPTH));
    end
  end

  // glyph byte address
  always_ff @(posedge clk) begin
    if (rst) begin
      g_valid <= 1'b0;
    end else if (adv) begin
      g_valid <= f_valid;
      g_op    <= f_op;
      g_wa    <= f_wa;
      g_wd    <= f_wd;
      g_px_lo <= f_px_lo;
      g_ok    <= f_ok && (f_code >= 8'(tgpg_pkg::FIRST_CODE));
      g_addr  <= tgpg_pkg::GADDR_W'((f_code - 8'(tgpg_pkg::FIRST_CODE)) * bpg)
                 + tgpg_pkg::GADDR_W'(f_base);
    end
  end

  // glyph memory port
  always_ff @(posedge clk) begin
    if (adv) begin
      if (g_valid && g_op == tgpg_pkg::OP_GLYPH && {3'd0, g_wa} < 15'(FONT_BYTES)) begin
        glyph_mem[GA_W'(g_wa)] <= g_wd;
      end
      h_glyph <= glyph_mem[g_addr[GA_W-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h_valid <= 1'b0;
    end else if (adv) begin
      h_valid <= g_valid;
      h_op    <= g_op;
      h_px_lo <= g_px_lo;
      h_ok    <= g_ok && (g_addr < tgpg_pkg::GADDR_W'(FONT_BYTES));
    end
  end

  assign m_tvalid = h_valid && h_op == tgpg_pkg::OP_QUERY;
  assign m_tdata  = {7'd0, h_ok && h_glyph[3'd7 - h_px_lo]};

endmodule
`default_nettype wire

[test/text_glyph_pixel_generator_top_test.sv]
`timescale 1ns / 100ps
module text_glyph_pixel_generator_top_test;

  localparam int TEXT_N = tgpg_pkg::TEXT_DEPTH_DEF;
  localparam int FONT_N = tgpg_pkg::FONT_BYTES_DEF;
  localparam int WATCHDOG_LIMIT = 5000;
  localparam int SETTLE = 30;
  // keep every glyph that a stored code can reach inside the written part of the font
  localparam int CODE_SPAN = 4;
  localparam int MAX_BPG = 140;
  localparam int GLYPH_FILL = tgpg_pkg::GLYPH_BASE + CODE_SPAN * MAX_BPG;

  class pixel_scoreboard;
    int unsigned gwid, ghei, wwid, tlen;
    bit [7:0] text_mem[TEXT_N];
    bit [7:0] font_mem[FONT_N];
    bit pixel_q[$];
    int mismatches;

    function new();
      gwid = 8; ghei = 8; wwid = 240; tlen = 0; mismatches = 0;
    endfunction

    function void set_reg(tgpg_pkg::reg_idx_t idx, bit [31:0] val);
      case (idx)
        tgpg_pkg::REG_GLYPH_WIDTH:  gwid = 32'(val[5:0]);
        tgpg_pkg::REG_GLYPH_HEIGHT: ghei = 32'(val[5:0]);
        tgpg_pkg::REG_WINDOW_WIDTH: wwid = 32'(val[10:0]);
        tgpg_pkg::REG_TEXT_LENGTH:  tlen = 32'(val[8:0]);
        default: ;
      endcase
    endfunction

    function bit glyph_bit(int unsigned px, int unsigned py);
      int unsigned gw, cpl, col, idx, code, bpr, addr;
      gw = gwid & ~32'd7;
      if (gw == 0 || ghei == 0) return 0;
      cpl = wwid / gw;
      if (cpl == 0) return 0;
      col = px / gw;
      if (col >= cpl) return 0;
      idx = (py / ghei) * cpl + col;
      if (idx >= tlen || idx >= TEXT_N) return 0;
      code = text_mem[idx];
      if (code < tgpg_pkg::FIRST_CODE) return 0;
      bpr = gw / 8;
      addr = tgpg_pkg::GLYPH_BASE + (code - tgpg_pkg::FIRST_CODE) * bpr * ghei
             + (px % gw) / 8 + (py % ghei) * bpr;
      if (addr >= FONT_N) return 0;
      return (font_mem[addr] & (8'h80 >> (px % 8))) != 0;
    endfunction

    function void note_request(tgpg_pkg::op_t op, bit [9:0] px, bit [9:0] py, bit [11:0] wa,
                               bit [7:0] wd);
      case (op)
        tgpg_pkg::OP_QUERY: pixel_q.push_back(glyph_bit(px, py));
        tgpg_pkg::OP_TEXT:  if (wa < TEXT_N) text_mem[wa] = wd;
        tgpg_pkg::OP_GLYPH: if (wa < FONT_N) font_mem[wa] = wd;
        default: ;
      endcase
    endfunction

    function void check_pixel(bit got);
      bit want;
      if (pixel_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result pixel_on=%0d", got);
        return;
      end
      want = pixel_q.pop_front();
      if (want !== got) begin
        mismatches++;
        if (mismatches <= 10) $display("pixel_on mismatch: expected %0d actual %0d", want, got);
      end
    endfunction
  endclass

  logic        clk, rst;
  logic        s_tvalid, s_tready;
  logic [39:0] s_tdata;
  logic [1:0]  s_tuser;
  logic        m_tvalid, m_tready;
  logic [7:0]  m_tdata;
  logic        psel, penable, pwrite, pready;
  logic [3:0]  paddr;
  logic [31:0] pwdata, prdata;

  pixel_scoreboard sb;
  bit idle_en;
  bit long_hold;
  int stall_cnt;
  int quiet_cycles;

  text_glyph_pixel_generator_top u_top (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  initial begin
    quiet_cycles = 0;
    forever begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  initial begin
    m_tready = 0;
    stall_cnt = 0;
    forever begin
      @(posedge clk);
      if (!rst && m_tvalid && m_tready) sb.check_pixel(m_tdata[0]);
      if (stall_cnt > 0) begin
        stall_cnt--;
        m_tready <= 0;
      end else if (long_hold) begin
        long_hold = 0;
        stall_cnt = 400;
        m_tready <= 0;
      end else if (idle_en && $urandom_range(0, 7) == 0) begin
        stall_cnt = $urandom_range(1, 7) - 1;
        m_tready <= 0;
      end else begin
        m_tready <= 1;
      end
    end
  end

  function automatic bit [7:0] pick_code();
    if ($urandom_range(0, 7) == 0) return 8'($urandom_range(0, tgpg_pkg::FIRST_CODE - 1));
    return 8'(tgpg_pkg::FIRST_CODE + $urandom_range(0, CODE_SPAN - 1));
  endfunction

  task automatic send(tgpg_pkg::op_t op, bit [9:0] px, bit [9:0] py, bit [11:0] wa,
                      bit [7:0] wd);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      s_tvalid <= 0;
      repeat ($urandom_range(1, 7)) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= op;
    s_tdata <= {wd, wa, py, px};
    do @(posedge clk); while (!s_tready);
    sb.note_request(op, px, py, wa, wd);
  endtask

  task automatic reg_write(tgpg_pkg::reg_idx_t idx, bit [31:0] val);
    psel <= 1;
    penable <= 0;
    pwrite <= 1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1;
    do @(posedge clk); while (!pready);
    psel <= 0;
    penable <= 0;
    sb.set_reg(idx, val);
    @(posedge clk);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    while (sb.pixel_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic configure(int gw, int gh, int ww, int tl);
    reg_write(tgpg_pkg::REG_GLYPH_WIDTH, gw);
    reg_write(tgpg_pkg::REG_GLYPH_HEIGHT, gh);
    reg_write(tgpg_pkg::REG_WINDOW_WIDTH, ww);
    reg_write(tgpg_pkg::REG_TEXT_LENGTH, tl);
  endtask

  task automatic random_requests(int n);
    int unsigned gw, cpl, xmax, ymax;
    bit [9:0] px, py;
    bit [11:0] wa;
    bit [7:0] wd;
    int pick;
    gw = sb.gwid & ~32'd7;
    cpl = (gw == 0) ? 0 : sb.wwid / gw;
    xmax = (sb.wwid == 0) ? 0 : ((sb.wwid - 1 > 1023) ? 1023 : sb.wwid - 1);
    ymax = (cpl == 0) ? 1023 : (sb.tlen / cpl + 1) * sb.ghei;
    if (ymax > 1023) ymax = 1023;
    for (int i = 0; i < n; i++) begin
      pick = $urandom_range(0, 15);
      wa = 12'($urandom);
      wd = 8'($urandom);
      if (pick < 11) begin
        px = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, xmax));
        py = ($urandom_range(0, 7) == 0) ? 10'($urandom) : 10'($urandom_range(0, ymax));
        send(tgpg_pkg::OP_QUERY, px, py, wa, wd);
      end else if (pick < 13) begin
        if ($urandom_range(0, 3) != 0) wa = 12'($urandom_range(0, TEXT_N - 1));
        send(tgpg_pkg::OP_TEXT, 10'($urandom), 10'($urandom), wa, pick_code());
      end else if (pick < 15) begin
        send(tgpg_pkg::OP_GLYPH, 10'($urandom), 10'($urandom), wa, wd);
      end else begin
        send(tgpg_pkg::OP_NONE, 10'($urandom), 10'($urandom), wa, wd);
      end
    end
  endtask

  task automatic directed_requests();
    send(tgpg_pkg::OP_TEXT, 0, 0, 0, 5);
    send(tgpg_pkg::OP_TEXT, 0, 0, 1, 8'd33);
    send(tgpg_pkg::OP_TEXT, 0, 0, 2, 32);
    send(tgpg_pkg::OP_TEXT, 0, 0, 12'hFFF, 8'hFF);
    send(tgpg_pkg::OP_GLYPH, 0, 0, 4, 8'h80);
    send(tgpg_pkg::OP_GLYPH, 0, 0, 11, 8'h01);
    send(tgpg_pkg::OP_GLYPH, 10'h3FF, 10'h3FF, 12'hFFF, 8'hFF);
    send(tgpg_pkg::OP_QUERY, 0, 0, 0, 0);
    send(tgpg_pkg::OP_QUERY, 8, 0, 12'hFFF, 8'hFF);
    send(tgpg_pkg::OP_QUERY, 16, 0, 0, 0);
    send(tgpg_pkg::OP_QUERY, 17, 0, 0, 0);
    send(tgpg_pkg::OP_QUERY, 23, 7, 0, 0);
    send(tgpg_pkg::OP_QUERY, 239, 63, 0, 0);
    send(tgpg_pkg::OP_QUERY, 10'h3FF, 0, 0, 0);
    send(tgpg_pkg::OP_QUERY, 0, 10'h3FF, 0, 0);
    send(tgpg_pkg::OP_QUERY, 10'h3FF, 10'h3FF, 12'hFFF, 8'hFF);
    send(tgpg_pkg::OP_NONE, 10'h3FF, 10'h3FF, 12'hFFF, 8'hFF);
    send(tgpg_pkg::OP_NONE, 0, 0, 0, 0);
    send(tgpg_pkg::OP_QUERY, 0, 64, 0, 0);
  endtask

  int phase_cfg[11][4] = '{
    '{8, 8, 240, 256}, '{16, 12, 1024, 256}, '{32, 32, 1024, 256}, '{8, 1, 1, 100},
    '{13, 63, 200, 256}, '{0, 8, 240, 50}, '{24, 0, 500, 200}, '{63, 20, 2047, 511},
    '{32, 8, 16, 256}, '{8, 16, 64, 0}, '{8, 8, 240, 256}
  };

  initial begin
    sb = new();
    idle_en = 0;
    long_hold = 0;
    rst = 1;
    s_tvalid = 0;
    s_tdata = '0;
    s_tuser = '0;
    psel = 0;
    penable = 0;
    pwrite = 0;
    paddr = '0;
    pwdata = '0;
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    for (int a = 0; a < TEXT_N; a++)
      send(tgpg_pkg::OP_TEXT, 0, 0, 12'(a), pick_code());
    for (int a = 0; a < GLYPH_FILL; a++)
      send(tgpg_pkg::OP_GLYPH, 0, 0, 12'(a), 8'($urandom));
    drain();
    configure(8, 8, 240, 256);
    idle_en = 1;
    directed_requests();
    drain();
    for (int p = 0; p < 11; p++) begin
      configure(phase_cfg[p][0], phase_cfg[p][1], phase_cfg[p][2], phase_cfg[p][3]);
      if (p == 10) idle_en = 0;
      if (p == 2) long_hold = 1;
      random_requests(60);
      drain();
    end
    if (sb.pixel_q.size() > 0) sb.mismatches++;
    if (sb.mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end
endmodule
